>>> src/audio_frame_header_checker_assert.svh
// Assertion macros shared by the frame header checker modules.
// Expects signals named clk and rst in the scope of each use.
`ifndef AUDIO_FRAME_HEADER_CHECKER_ASSERT_SVH
`define AUDIO_FRAME_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define AFHC_ASSERT_NOW(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define AFHC_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error(msg);

`endif

>>> src/afhc_pkg.sv
// Shared types, constants and helpers for the audio frame header checker.
// No dependencies; the design modules and the bench import this package.
package afhc_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_TALK_ACQUIRE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_TALK_AUDIO   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_TALK_RELEASE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_MIC_AUDIO    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STATE_REPORT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_ERROR_REPORT = 3'd7;

  localparam logic [7:0]  RST_EXPECTED_VERSION  = 8'd1;
  localparam logic [15:0] RST_MAX_PAYLOAD_BYTES = 16'd1024;
  localparam logic [7:0]  RST_CODE_TALK_ACQUIRE = 8'd1;
  localparam logic [7:0]  RST_CODE_TALK_AUDIO   = 8'd2;
  localparam logic [7:0]  RST_CODE_TALK_RELEASE = 8'd3;
  localparam logic [7:0]  RST_CODE_MIC_AUDIO    = 8'd4;
  localparam logic [7:0]  RST_CODE_STATE_REPORT = 8'd5;
  localparam logic [7:0]  RST_CODE_ERROR_REPORT = 8'd6;

  // Verdict status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_PROTOCOL  = 2'd2;
  localparam logic [1:0] STATUS_SIZE      = 2'd3;

  // Byte counter and header layout
  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_TOP  = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] HEADER_LEN = 17'd16;
  localparam logic [7:0]         HEADER_SIZE_BYTE = 8'd16;

  localparam logic [3:0] OFS_VERSION   = 4'd4;
  localparam logic [3:0] OFS_TYPE      = 4'd5;
  localparam logic [3:0] OFS_FLAGS     = 4'd6;
  localparam logic [3:0] OFS_HDR_SIZE  = 4'd7;
  localparam logic [3:0] OFS_SEQ_END   = 4'd12;
  localparam logic [3:0] OFS_LEN_END   = 4'd14;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] sequence_number;
    logic [15:0] payload_bytes;
  } verdict_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] max_payload_bytes;
    logic [7:0]  code_talk_acquire;
    logic [7:0]  code_talk_audio;
    logic [7:0]  code_talk_release;
    logic [7:0]  code_mic_audio;
    logic [7:0]  code_state_report;
    logic [7:0]  code_error_report;
  } cfg_t;

  // Per-frame record handed from the front to the back
  typedef struct packed {
    logic        short_frame;
    logic        fixed_bad;
    logic        len_match;
    logic [7:0]  type_byte;
    logic [7:0]  flags_byte;
    logic [31:0] seq;
    logic [15:0] len;
  } summary_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4A;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h55;
      default: b = 8'h44;
    endcase
    return b;
  endfunction

endpackage

>>> src/afhc_front.sv
// Front end: counts frame bytes, checks fixed header fields, captures the rest.
// Depends on afhc_pkg.
module afhc_front import afhc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_word_t word,
  input  logic [7:0] expected_version,
  output logic       push,
  output summary_t   summary
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               fixed_bad, fixed_bad_next;
  logic [7:0]         type_byte, type_byte_next;
  logic [7:0]         flags_byte, flags_byte_next;
  logic [31:0]        seq_shift, seq_shift_next;
  logic [15:0]        len_shift, len_shift_next;
  logic               reserved_nz, reserved_nz_next;
  logic [3:0]         pos;

  assign pos = byte_count[3:0];

  always_comb begin
    byte_count_next  = byte_count;
    fixed_bad_next   = fixed_bad;
    type_byte_next   = type_byte;
    flags_byte_next  = flags_byte;
    seq_shift_next   = seq_shift;
    len_shift_next   = len_shift;
    reserved_nz_next = reserved_nz;
    if (byte_count < HEADER_LEN) begin
      if (pos < OFS_VERSION) begin
        if (word.in_byte != magic_byte(pos[1:0])) fixed_bad_next = 1'b1;
      end else if (pos == OFS_VERSION) begin
        if (word.in_byte != expected_version) fixed_bad_next = 1'b1;
      end else if (pos == OFS_TYPE) begin
        type_byte_next = word.in_byte;
      end else if (pos == OFS_FLAGS) begin
        flags_byte_next = word.in_byte;
      end else if (pos == OFS_HDR_SIZE) begin
        if (word.in_byte != HEADER_SIZE_BYTE) fixed_bad_next = 1'b1;
      end else if (pos < OFS_SEQ_END) begin
        seq_shift_next = {seq_shift[23:0], word.in_byte};
      end else if (pos < OFS_LEN_END) begin
        len_shift_next = {len_shift[7:0], word.in_byte};
      end else begin
        if (word.in_byte != 8'd0) reserved_nz_next = 1'b1;
      end
    end
    // saturate at the top so an overlong frame never matches a valid total
    if (byte_count != COUNT_TOP) byte_count_next = byte_count + 1'b1;
  end

  assign push = take && word.last_byte;

  always_comb begin
    summary.short_frame = byte_count_next < HEADER_LEN;
    summary.fixed_bad   = fixed_bad_next || reserved_nz_next;
    summary.len_match   = byte_count_next == (COUNT_W'(len_shift_next) + HEADER_LEN);
    summary.type_byte   = type_byte_next;
    summary.flags_byte  = flags_byte_next;
    summary.seq         = seq_shift_next;
    summary.len         = len_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count  <= '0;
      fixed_bad   <= 1'b0;
      type_byte   <= '0;
      flags_byte  <= '0;
      seq_shift   <= '0;
      len_shift   <= '0;
      reserved_nz <= 1'b0;
    end else if (take) begin
      byte_count  <= byte_count_next;
      fixed_bad   <= fixed_bad_next;
      type_byte   <= type_byte_next;
      flags_byte  <= flags_byte_next;
      seq_shift   <= seq_shift_next;
      len_shift   <= len_shift_next;
      reserved_nz <= reserved_nz_next;
    end
  end

endmodule

>>> src/afhc_queue.sv
// Small FIFO of frame records between the front and the back.
// Depends on afhc_pkg and the shared assertion header.
`include "audio_frame_header_checker_assert.svh"
module afhc_queue import afhc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  summary_t push_data,
  input  logic     pop,
  output summary_t pop_data,
  output logic     full,
  output logic     empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  summary_t           slots [DEPTH];
  logic [IDX_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `AFHC_ASSERT_NOW(a_no_push_full, push, !full, "frame record pushed into a full queue")
  `AFHC_ASSERT_NOW(a_no_pop_empty, pop, !empty, "frame record popped from an empty queue")
  `AFHC_ASSERT_NEXT(a_drain_last, pop && !push && count == CNT_W'(1), empty,
                    "queue not empty after its last record left")

endmodule

>>> src/afhc_back.sv
// Back end: judges one frame record against the configuration, holds the verdict.
// Depends on afhc_pkg and the shared assertion header.
`include "audio_frame_header_checker_assert.svh"
module afhc_back import afhc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_empty,
  input  summary_t q_data,
  output logic     pop,
  output logic     verdict_valid,
  input  logic     verdict_stall,
  output verdict_t verdict
);

  logic       is_acquire, is_audio, is_release, is_mic, known;
  logic       empty_only, needs_payload;
  logic [1:0] status;
  verdict_t   result;

  always_comb begin
    is_acquire    = q_data.type_byte == cfg.code_talk_acquire;
    is_audio      = q_data.type_byte == cfg.code_talk_audio;
    is_release    = q_data.type_byte == cfg.code_talk_release;
    is_mic        = q_data.type_byte == cfg.code_mic_audio;
    known         = is_acquire || is_audio || is_release || is_mic ||
                    q_data.type_byte == cfg.code_state_report ||
                    q_data.type_byte == cfg.code_error_report;
    empty_only    = is_acquire || is_release;
    needs_payload = is_audio || is_mic;

    if (q_data.short_frame) begin
      status = STATUS_SHORT;
    end else if (q_data.fixed_bad || !known || q_data.seq == 32'd0) begin
      status = STATUS_PROTOCOL;
    end else if (q_data.len > cfg.max_payload_bytes || !q_data.len_match) begin
      status = STATUS_SIZE;
    end else if (empty_only && q_data.len != 16'd0) begin
      status = STATUS_PROTOCOL;
    end else if (needs_payload && q_data.len == 16'd0) begin
      status = STATUS_PROTOCOL;
    end else begin
      status = STATUS_OK;
    end

    result = '0;
    result.status = status;
    if (status == STATUS_OK) begin
      result.frame_type      = q_data.type_byte;
      result.frame_flags     = q_data.flags_byte;
      result.sequence_number = q_data.seq;
      result.payload_bytes   = q_data.len;
    end
  end

  assign pop = !q_empty && (!verdict_valid || !verdict_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (pop) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) verdict <= result;
  end

  `AFHC_ASSERT_NEXT(a_pop_shows, pop, verdict_valid, "popped record did not reach the output")
  `AFHC_ASSERT_NOW(a_fail_zero, verdict_valid && verdict.status != STATUS_OK,
                   verdict.frame_type == 8'd0 && verdict.frame_flags == 8'd0 &&
                   verdict.sequence_number == 32'd0 && verdict.payload_bytes == 16'd0,
                   "failed verdict carries header fields")

endmodule

>>> src/audio_frame_header_checker.sv
// Top level of the audio frame header checker: configuration registers and wiring
// of front end, record queue and back end. Depends on afhc_pkg, afhc_front,
// afhc_queue and afhc_back.
//
//   channel   direction  word         handshake
//   byte      in         byte_word    byte_valid / byte_stall
//   verdict   out        verdict      verdict_valid / verdict_stall
//   config    in         cfg_data     cfg_write, cfg_index (no handshake)
//
// Takes one byte per cycle while byte_stall is low; frames may follow each other with no gap.
// When the last byte is taken, the frame record is written into the queue; it is
// then judged and registered as the verdict once the verdict output can take it.
// byte_stall rises only while the record queue holds QUEUE_DEPTH frames waiting
// on a stalled verdict output; non-final bytes are held off then too.
// Reset (rst, synchronous) empties the queue, clears the frame state and loads
// the register defaults; there is no clearing pass.
module audio_frame_header_checker import afhc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // byte input
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  byte_word_t             byte_word,
  // verdict output
  output logic                   verdict_valid,
  input  logic                   verdict_stall,
  output verdict_t               verdict,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  logic     take;
  logic     push, pop;
  logic     q_full, q_empty;
  summary_t push_rec, pop_rec;

  // Configuration registers. Writes must come only while no frame is in flight;
  // the block does not check it; front and back read them without hazard logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version  <= RST_EXPECTED_VERSION;
      cfg.max_payload_bytes <= RST_MAX_PAYLOAD_BYTES;
      cfg.code_talk_acquire <= RST_CODE_TALK_ACQUIRE;
      cfg.code_talk_audio   <= RST_CODE_TALK_AUDIO;
      cfg.code_talk_release <= RST_CODE_TALK_RELEASE;
      cfg.code_mic_audio    <= RST_CODE_MIC_AUDIO;
      cfg.code_state_report <= RST_CODE_STATE_REPORT;
      cfg.code_error_report <= RST_CODE_ERROR_REPORT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXPECTED_VERSION:  cfg.expected_version  <= cfg_data[7:0];
        CFG_MAX_PAYLOAD_BYTES: cfg.max_payload_bytes <= cfg_data;
        CFG_CODE_TALK_ACQUIRE: cfg.code_talk_acquire <= cfg_data[7:0];
        CFG_CODE_TALK_AUDIO:   cfg.code_talk_audio   <= cfg_data[7:0];
        CFG_CODE_TALK_RELEASE: cfg.code_talk_release <= cfg_data[7:0];
        CFG_CODE_MIC_AUDIO:    cfg.code_mic_audio    <= cfg_data[7:0];
        CFG_CODE_STATE_REPORT: cfg.code_state_report <= cfg_data[7:0];
        CFG_CODE_ERROR_REPORT: cfg.code_error_report <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold bytes off only while the queue cannot take another frame record.
  assign byte_stall = q_full;
  assign take       = byte_valid && !byte_stall;

  // Front: count bytes, check the fixed fields, capture type, flags, sequence
  // and length; on the last byte push one record and restart for the next frame.
  afhc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .word             (byte_word),
    .expected_version (cfg.expected_version),
    .push             (push),
    .summary          (push_rec)
  );

  // Queue: decouple byte intake from verdict delivery.
  afhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .pop_data  (pop_rec),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: apply the check priority and register the verdict word.
  afhc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (pop_rec),
    .pop           (pop),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

endmodule

>>> bench/tb_audio_frame_header_checker.sv
`timescale 1ns / 1ps
// Self-checking bench for audio_frame_header_checker: byte frames in, verdicts out.
// Depends on afhc_pkg and the checker RTL; a built-in predictor supplies expected verdicts.
module tb_audio_frame_header_checker;
  import afhc_pkg::*;

  localparam logic [31:0] FRAME_MAGIC = 32'h4A41_5544;  // "JAUD", big-endian
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 220;
  localparam int SETTLE_CYCLES = 8;

  // One frame to send: header fields, total byte count, optional fixed verdict.
  typedef struct {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [7:0]  hsize;
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] rsvd;
    int          total;
    bit          typed;
    logic [1:0]  typed_status;
  } frame_plan_t;

  // Per-frame note from the sender to the predictor.
  typedef struct {
    bit       typed;
    verdict_t v;
  } frame_note_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  byte_word_t byte_word;
  logic       verdict_valid;
  logic       verdict_stall = 1'b0;
  verdict_t   verdict;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  audio_frame_header_checker dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_word     (byte_word),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the registers and of the frame capture.
  cfg_t         cfg;
  logic [16:0]  seen_bytes;
  logic         header_bad;
  logic [7:0]   cap_type;
  logic [7:0]   cap_flags;
  logic [31:0]  cap_seq;
  logic [15:0]  cap_len;
  logic         rsvd_set;

  verdict_t     pending_verdicts[$];
  frame_note_t  frame_notes[$];
  frame_plan_t  directed_rows[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int status_seen[4] = '{0, 0, 0, 0};

  // Sender burst bookkeeping.
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // Receiver stall pattern.
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;
  bit stall_next;

  function automatic void clear_frame();
    seen_bytes = '0;
    header_bad = 1'b0;
    cap_type   = '0;
    cap_flags  = '0;
    cap_seq    = '0;
    cap_len    = '0;
    rsvd_set   = 1'b0;
  endfunction

  // Expected verdict for a frame that ends with total bytes, in check priority order.
  function automatic verdict_t judge_frame(logic [16:0] total);
    verdict_t v;
    logic     known;
    logic     need_empty;
    logic     need_data;
    v = '0;
    known = cap_type == cfg.code_talk_acquire || cap_type == cfg.code_talk_audio ||
            cap_type == cfg.code_talk_release || cap_type == cfg.code_mic_audio ||
            cap_type == cfg.code_state_report || cap_type == cfg.code_error_report;
    need_empty = cap_type == cfg.code_talk_acquire || cap_type == cfg.code_talk_release;
    need_data  = cap_type == cfg.code_talk_audio || cap_type == cfg.code_mic_audio;
    if (total < HEADER_LEN) begin
      v.status = STATUS_SHORT;
    end else if (header_bad || !known || cap_seq == '0 || rsvd_set) begin
      v.status = STATUS_PROTOCOL;
    end else if (cap_len > cfg.max_payload_bytes || total != HEADER_LEN + {1'b0, cap_len}) begin
      v.status = STATUS_SIZE;
    end else if ((need_empty && cap_len != '0) || (need_data && cap_len == '0)) begin
      v.status = STATUS_PROTOCOL;
    end else begin
      v.status          = STATUS_OK;
      v.frame_type      = cap_type;
      v.frame_flags     = cap_flags;
      v.sequence_number = cap_seq;
      v.payload_bytes   = cap_len;
    end
    return v;
  endfunction

  // Advance the predictor by one accepted byte; queue a verdict on the last one.
  task automatic take_byte(byte_word_t w);
    frame_note_t note;
    verdict_t    want;
    int          pos;
    pos = int'(seen_bytes);
    bytes_sent++;
    if (pos < 16) begin
      case (pos)
        0, 1, 2, 3: if (w.in_byte != FRAME_MAGIC[8*(3-pos) +: 8]) header_bad = 1'b1;
        4:          if (w.in_byte != cfg.expected_version) header_bad = 1'b1;
        5:          cap_type = w.in_byte;
        6:          cap_flags = w.in_byte;
        7:          if (w.in_byte != HEADER_SIZE_BYTE) header_bad = 1'b1;
        8, 9, 10, 11: cap_seq = {cap_seq[23:0], w.in_byte};
        12, 13:     cap_len = {cap_len[7:0], w.in_byte};
        default:    if (w.in_byte != 8'h00) rsvd_set = 1'b1;
      endcase
    end
    // Saturate the count; an overlong frame can then never match a legal total.
    if (seen_bytes != COUNT_TOP) seen_bytes++;
    if (w.last_byte) begin
      want = judge_frame(seen_bytes);
      if (frame_notes.size() != 0) begin
        note = frame_notes.pop_front();
        if (note.typed) want = note.v;
      end
      pending_verdicts.push_back(want);
      clear_frame();
    end
  endtask

  function automatic void report_mismatch(string what, verdict_t want, verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want st=%0d ty=%02h fl=%02h seq=%08h len=%0d", $time, what,
               want.status, want.frame_type, want.frame_flags, want.sequence_number,
               want.payload_bytes, "\n    got st=%0d ty=%02h fl=%02h seq=%08h len=%0d",
               got.status, got.frame_type, got.frame_flags, got.sequence_number,
               got.payload_bytes);
  endfunction

  task automatic check_verdict(verdict_t got);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch("verdict with nothing pending", '0, got);
    end else begin
      want = pending_verdicts.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status || got.frame_type !== want.frame_type ||
          got.frame_flags !== want.frame_flags ||
          got.sequence_number !== want.sequence_number ||
          got.payload_bytes !== want.payload_bytes)
        report_mismatch("verdict mismatch", want, got);
    end
  endtask

  // Sample both channels mid-cycle: what is seen here is what the next rising edge takes.
  always @(negedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) take_byte(byte_word);
      if (verdict_valid && !verdict_stall) check_verdict(verdict);
    end
  end

  // Receiver: switch among stall patterns now and then; a hold request overrides
  // everything and keeps the output stalled while its hold counter, kept here, runs down.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    stall_tick++;
    if (hold_left != 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (stall_mode)
        0:       stall_next = 1'b0;
        1:       stall_next = $urandom_range(0, 2) == 0;
        2:       stall_next = (stall_tick % 5) < 3;
        default: stall_next = $urandom_range(0, 3) != 0;
      endcase
    end
    verdict_stall <= stall_next;
  end

  // Offer one word and hold it until taken. Between bursts of random length,
  // drop valid for a random gap, unless the current frame is sent steady.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    bit taken;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_valid <= 1'b1;
    byte_word  <= '{in_byte: b, last_byte: last};
    do begin
      @(negedge clk);
      taken = !byte_stall;
      @(posedge clk);
    end while (!taken);
    if (burst_left != 0) burst_left--;
  endtask

  function automatic logic [7:0] header_byte(frame_plan_t p, int i);
    logic [7:0] b;
    case (i)
      0, 1, 2, 3:     b = p.magic[8*(3-i) +: 8];
      4:              b = p.version;
      5:              b = p.ftype;
      6:              b = p.flags;
      7:              b = p.hsize;
      8, 9, 10, 11:   b = p.seq[8*(11-i) +: 8];
      12, 13:         b = p.len[8*(13-i) +: 8];
      14, 15:         b = p.rsvd[8*(15-i) +: 8];
      default:        b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic feed_frame(frame_plan_t p);
    frame_note_t n;
    n.typed = p.typed;
    n.v = '0;
    n.v.status = p.typed_status;
    if (p.typed_status == STATUS_OK) begin
      n.v.frame_type      = p.ftype;
      n.v.frame_flags     = p.flags;
      n.v.sequence_number = p.seq;
      n.v.payload_bytes   = p.len;
    end
    frame_notes.push_back(n);
    // Long frames go through without gaps to keep the run short.
    sender_steady = p.total > 1000;
    for (int i = 0; i < p.total; i++) send_byte(header_byte(p, i), i == p.total - 1);
    sender_steady = 1'b0;
    frames_sent++;
  endtask

  // A well-formed frame under the current registers, random flags and sequence.
  function automatic frame_plan_t good_frame(logic [7:0] ftype, logic [15:0] len);
    frame_plan_t p;
    p.magic   = FRAME_MAGIC;
    p.version = cfg.expected_version;
    p.ftype   = ftype;
    p.flags   = 8'($urandom);
    p.hsize   = HEADER_SIZE_BYTE;
    p.seq     = $urandom;
    if (p.seq == '0) p.seq = 32'd1;
    p.len     = len;
    p.rsvd    = '0;
    p.total   = 16 + int'(len);
    p.typed   = 1'b0;
    p.typed_status = STATUS_OK;
    return p;
  endfunction

  function automatic void add_row(frame_plan_t p, bit typed, logic [1:0] st);
    p.typed = typed;
    p.typed_status = st;
    directed_rows.push_back(p);
  endfunction

  // Mostly legal frames with random content; a quarter broken in one place; the
  // rest plain noise.
  function automatic frame_plan_t random_plan();
    frame_plan_t p;
    logic [7:0]  codes[6];
    logic [7:0]  t;
    int          kind;
    int          lim;
    int          k;
    codes[0] = cfg.code_talk_acquire;
    codes[1] = cfg.code_talk_audio;
    codes[2] = cfg.code_talk_release;
    codes[3] = cfg.code_mic_audio;
    codes[4] = cfg.code_state_report;
    codes[5] = cfg.code_error_report;
    lim = (cfg.max_payload_bytes > 40) ? 40 : int'(cfg.max_payload_bytes);
    if ($urandom_range(0, 19) == 0 && cfg.max_payload_bytes > 40)
      lim = (cfg.max_payload_bytes > 600) ? 600 : int'(cfg.max_payload_bytes);
    t = codes[$urandom_range(0, 5)];
    if (t == cfg.code_talk_acquire || t == cfg.code_talk_release)
      p = good_frame(t, 16'd0);
    else if (t == cfg.code_talk_audio || t == cfg.code_mic_audio)
      p = good_frame(t, 16'((lim == 0) ? 1 : $urandom_range(1, lim)));
    else
      p = good_frame(t, 16'($urandom_range(0, lim)));
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      p.magic   = $urandom;
      p.version = 8'($urandom);
      p.ftype   = 8'($urandom);
      p.hsize   = 8'($urandom);
      p.seq     = $urandom;
      p.len     = 16'($urandom);
      p.rsvd    = 16'($urandom);
      p.total   = $urandom_range(1, 48);
    end else if (kind >= 65) begin
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 10))
        0:  p.magic[8*k +: 8] = p.magic[8*k +: 8] ^ 8'($urandom_range(1, 255));
        1:  p.version = p.version ^ 8'($urandom_range(1, 255));
        2:  p.ftype = 8'($urandom);
        3:  p.hsize = p.hsize ^ 8'($urandom_range(1, 255));
        4:  p.seq = '0;
        5:  p.rsvd = 16'($urandom_range(1, 65535));
        6: begin
          p.len = (cfg.max_payload_bytes < 16'hFFF8)
                  ? cfg.max_payload_bytes + 16'($urandom_range(1, 8)) : 16'($urandom);
          p.total = (p.len > 600) ? 16 + $urandom_range(0, 64) : 16 + int'(p.len);
        end
        7:  p.total = p.total + $urandom_range(1, 3);
        8:  p.total = $urandom_range(1, p.total - 1);
        9:  p.total = $urandom_range(1, 15);
        default: begin
          // Flip the empty/nonempty payload rule.
          p.len = (p.len == '0) ? 16'($urandom_range(1, 8)) : 16'd0;
          p.total = 16 + int'(p.len);
        end
      endcase
    end
    return p;
  endfunction

  // Write all eight registers on back-to-back edges; keep the predictor copy in step.
  task automatic load_config(cfg_t c);
    logic [CFG_INDEX_W-1:0] idx[8];
    logic [CFG_DATA_W-1:0]  val[8];
    idx = '{CFG_EXPECTED_VERSION, CFG_MAX_PAYLOAD_BYTES, CFG_CODE_TALK_ACQUIRE,
            CFG_CODE_TALK_AUDIO, CFG_CODE_TALK_RELEASE, CFG_CODE_MIC_AUDIO,
            CFG_CODE_STATE_REPORT, CFG_CODE_ERROR_REPORT};
    val = '{16'(c.expected_version), c.max_payload_bytes, 16'(c.code_talk_acquire),
            16'(c.code_talk_audio), 16'(c.code_talk_release), 16'(c.code_mic_audio),
            16'(c.code_state_report), 16'(c.code_error_report)};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cfg = c;
    settings_used++;
  endtask

  // Pause the sender until every expected verdict is in, then let the pipe settle.
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random type codes; a narrow range makes codes likely to collide.
  function automatic void k_codes(inout cfg_t c, input bit narrow);
    int top;
    top = narrow ? 7 : 255;
    c.code_talk_acquire = 8'($urandom_range(0, top));
    c.code_talk_audio   = 8'($urandom_range(0, top));
    c.code_talk_release = 8'($urandom_range(0, top));
    c.code_mic_audio    = 8'($urandom_range(0, top));
    c.code_state_report = 8'($urandom_range(0, top));
    c.code_error_report = 8'($urandom_range(0, top));
  endfunction

  initial begin
    cfg_t        c;
    frame_plan_t r;
    int          phase_start;
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_word  = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_EXPECTED_VERSION;
    cfg_data   = '0;
    cfg = '{expected_version: RST_EXPECTED_VERSION,
            max_payload_bytes: RST_MAX_PAYLOAD_BYTES,
            code_talk_acquire: RST_CODE_TALK_ACQUIRE,
            code_talk_audio: RST_CODE_TALK_AUDIO,
            code_talk_release: RST_CODE_TALK_RELEASE,
            code_mic_audio: RST_CODE_MIC_AUDIO,
            code_state_report: RST_CODE_STATE_REPORT,
            code_error_report: RST_CODE_ERROR_REPORT};
    clear_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values. Fixed verdicts where the
    // answer is obvious; the rest go through the predictor.
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);
    r.flags = 8'hFF;
    r.seq = 32'hFFFF_FFFF;
    add_row(r, 1'b1, STATUS_OK);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.total = 1;
    add_row(r, 1'b1, STATUS_SHORT);
    r = good_frame(RST_CODE_STATE_REPORT, 16'd0);  r.total = 15;
    add_row(r, 1'b1, STATUS_SHORT);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.magic[31:24] = 8'h00;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.version = 8'h00;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.version = 8'hFF;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.hsize = 8'd17;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(8'h00, 16'd0);
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(8'hFF, 16'd0);
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.seq = '0;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.rsvd = 16'h0001;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.rsvd = 16'h8000;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    // Audio types must carry a payload, acquire and release must not.
    r = good_frame(RST_CODE_TALK_AUDIO, 16'd0);
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_MIC_AUDIO, 16'd0);
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_RELEASE, 16'd1);
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_AUDIO, 16'd4);  r.flags = 8'h00;  r.seq = 32'd1;
    add_row(r, 1'b0, STATUS_OK);
    r = good_frame(RST_CODE_MIC_AUDIO, RST_MAX_PAYLOAD_BYTES + 16'd1);  r.total = 17;
    add_row(r, 1'b1, STATUS_SIZE);
    r = good_frame(RST_CODE_STATE_REPORT, 16'd3);  r.total = 18;
    add_row(r, 1'b1, STATUS_SIZE);
    r = good_frame(RST_CODE_ERROR_REPORT, 16'd0);  r.total = 17;
    add_row(r, 1'b1, STATUS_SIZE);
    r = good_frame(RST_CODE_STATE_REPORT, 16'hFFFF);  r.total = 17;
    add_row(r, 1'b1, STATUS_SIZE);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);
    add_row(r, 1'b0, STATUS_OK);
    // Header fault outranks size fault; short outranks both.
    r = good_frame(RST_CODE_TALK_AUDIO, 16'd2000);  r.seq = '0;  r.total = 40;
    add_row(r, 1'b1, STATUS_PROTOCOL);
    r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);  r.magic[7:0] = 8'h00;  r.total = 5;
    add_row(r, 1'b1, STATUS_SHORT);

    foreach (directed_rows[i]) feed_frame(directed_rows[i]);
    wait_idle();

    // Hold the verdict output off while one-byte frames keep coming, so the record
    // queue fills and the byte input stalls.
    hold_ask++;
    repeat (16) begin
      r = good_frame(RST_CODE_TALK_ACQUIRE, 16'd0);
      r.magic = $urandom;
      r.total = 1;
      feed_frame(r);
    end
    wait_idle();

    // Random frames under several register settings, extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: c = '{expected_version: 8'h00, max_payload_bytes: 16'h0000,
                 code_talk_acquire: 8'h00, code_talk_audio: 8'h01,
                 code_talk_release: 8'h02, code_mic_audio: 8'h03,
                 code_state_report: 8'h04, code_error_report: 8'h05};
        1: c = '{expected_version: 8'hFF, max_payload_bytes: 16'hFFFF,
                 code_talk_acquire: 8'hFF, code_talk_audio: 8'hFE,
                 code_talk_release: 8'hFD, code_mic_audio: 8'hFC,
                 code_state_report: 8'hFB, code_error_report: 8'hFA};
        // One code in several roles: all of its rules apply at once.
        2: c = '{expected_version: 8'h5A, max_payload_bytes: 16'd64,
                 code_talk_acquire: 8'h10, code_talk_audio: 8'h10,
                 code_talk_release: 8'h20, code_mic_audio: 8'h20,
                 code_state_report: 8'h30, code_error_report: 8'h10};
        default: begin
          c.expected_version  = 8'($urandom);
          c.max_payload_bytes = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 64));
          k_codes(c, ph == 5);
        end
      endcase
      load_config(c);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) feed_frame(random_plan());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      mismatches += pending_verdicts.size();
      $display("%0t %0d expected verdicts never arrived", $time, pending_verdicts.size());
    end
    $display("Run covered %0d frames (%0d bytes) under %0d register settings.",
             frames_sent, bytes_sent, settings_used);
    $display("Verdicts: ok %0d, short %0d, protocol %0d, size %0d; mismatches %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_SHORT],
             status_seen[STATUS_PROTOCOL], status_seen[STATUS_SIZE], mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up on a hung run well past the slowest legal finish.
  initial begin
    #10_000_000;
    $display("%0t timeout with %0d verdicts pending", $time, pending_verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
